// File: rtl/string_pitch_tuner_assert.svh
// Assertion macros shared by the string pitch tuner RTL.
// Define NO_ASSERTIONS to compile them out.
`ifndef STRING_PITCH_TUNER_ASSERT_SVH
`define STRING_PITCH_TUNER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SPT_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define SPT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define SPT_ASSERT_IMP(label, clk, rst, ante, cons)
`define SPT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: rtl/spt_pkg.sv
// Package for the string pitch tuner: sizes, constant tables, register indices.
// No dependencies.
package spt_pkg;
   localparam int PERIOD_SLOTS  = 6;
   localparam int HISTORY_DEPTH = 20;
   localparam int TICK_BITS     = 16;
   localparam int SLOT_BITS     = $clog2(PERIOD_SLOTS);
   localparam int HIST_BITS     = $clog2(HISTORY_DEPTH);
   localparam int HSUM_BITS     = $clog2(HISTORY_DEPTH * 9 + 1);
   localparam int SUM_BITS      = 18;
   localparam int FREQ_BITS     = 26;
   localparam int DIV_BITS      = 40;
   localparam logic [TICK_BITS-1:0] TICK_MAX = {TICK_BITS{1'b1}};
   localparam logic [15:0] GAIN_Q16 = 16'd64225;
   localparam logic [7:0]  BUMP_Q8  = 8'd151;
   // rounded history mean as (hsum + depth/2) * recip >> shift, exact for the
   // full history sum range
   localparam int SMOOTH_SHIFT  = 12;
   localparam int SMOOTH_RECIP  = ((1 << SMOOTH_SHIFT) + HISTORY_DEPTH - 1) / HISTORY_DEPTH;

   typedef enum logic [3:0] {
      CSR_SAMPLE_RATE = 4'd0, CSR_MIN_FREQ = 4'd1, CSR_MAX_FREQ = 4'd2,
      CSR_TIGHT_TOL = 4'd3, CSR_LOOSE_TOL = 4'd4
   } csr_index_type;

   // divider request and answer
   typedef struct packed {
      logic                start;
      logic [DIV_BITS-1:0] num;
      logic [DIV_BITS-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic                done;
      logic [DIV_BITS-1:0] quot;
   } div_rsp_type;

   function automatic logic [16:0] tone_q8(input logic [2:0] s);
      unique case (s)
         3'd0: tone_q8 = 17'd21094;  3'd1: tone_q8 = 17'd28160;
         3'd2: tone_q8 = 17'd37581;  3'd3: tone_q8 = 17'd50176;
         3'd4: tone_q8 = 17'd63206;  default: tone_q8 = 17'd84378;
      endcase
   endfunction

   function automatic logic [20:0] up_q16(input logic [2:0] s);
      unique case (s)
         3'd0: up_q16 = 21'd321111;  3'd1: up_q16 = 21'd428667;
         3'd2: up_q16 = 21'd572076;  3'd3: up_q16 = 21'd763807;
         3'd4: up_q16 = 21'd962163;  default: up_q16 = 21'd1284442;
      endcase
   endfunction

   function automatic logic [20:0] dn_q16(input logic [2:0] s);
      unique case (s)
         3'd0: dn_q16 = 21'd303088;  3'd1: dn_q16 = 21'd404608;
         3'd2: dn_q16 = 21'd539968;  3'd3: dn_q16 = 21'd720938;
         3'd4: dn_q16 = 21'd908161;  default: dn_q16 = 21'd1212352;
      endcase
   endfunction

   function automatic logic [16:0] band_q8(input logic [2:0] s);
      unique case (s)
         3'd0: band_q8 = 17'd24627;  3'd1: band_q8 = 17'd32870;
         3'd2: band_q8 = 17'd43878;  3'd3: band_q8 = 17'd56678;
         default: band_q8 = 17'd73805;
      endcase
   endfunction
endpackage

// File: rtl/string_pitch_tuner.sv
// String pitch tuner. Channels: req_ (one comparator bit per sample tick),
// rsp_ (one result per rising edge), csr_ (register writes, always ready).
// A sample that is not a rising edge is absorbed with no result, so such
// samples can follow back to back while no result waits.
// On a rising edge the sequencer runs the pattern search, frequency and detune
// on one shared 40-bit restoring divider: up to eight rate divisions, one
// frequency division and at most one detune division, then the 20-entry
// history is summed one entry per cycle. req_ready is low during that work
// and while a result waits. The result sits in an output register until
// rsp_ready; the block takes no new sample until it is taken.
// Reset (synchronous, active high) loads register defaults and clears the
// tick count, edge flag, period ring and history.
// Depends on spt_pkg, spt_divider and string_pitch_tuner_assert.svh.
`include "string_pitch_tuner_assert.svh"
module string_pitch_tuner import spt_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_signal_high,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [8:0]           rsp_led_pattern,
   output logic [3:0]           rsp_smoothed_index,
   output logic [3:0]           rsp_raw_index,
   output logic [SUM_BITS-1:0]  rsp_pattern_ticks,
   output logic [FREQ_BITS-1:0] rsp_freq_q8,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [3:0]           csr_index,
   input  logic [31:0]          csr_data
);
   typedef enum logic [7:0] {
      ST_IDLE = 8'b00000001, ST_SRCH = 8'b00000010, ST_SWAIT = 8'b00000100,
      ST_FREQ = 8'b00001000, ST_FWAIT = 8'b00010000, ST_DET = 8'b00100000,
      ST_DWAIT = 8'b01000000, ST_HIST = 8'b10000000
   } state_type;

   state_type state_ff, state_in;
   logic [17:0] rate_ff; logic [11:0] minf_ff, maxf_ff; logic [7:0] ttol_ff, ltol_ff;
   logic [TICK_BITS-1:0] tick_ff, tick_in;
   logic was_high_ff, was_high_in;
   logic [TICK_BITS-1:0] ring_ff [PERIOD_SLOTS];
   logic [SLOT_BITS-1:0] slot_ff, slot_in;
   logic [3:0] hist_ff [HISTORY_DEPTH];
   logic [HIST_BITS-1:0] hslot_ff, hslot_in;
   logic [2:0] n_ff, n_in;          // candidate 1..4
   logic pass_ff, pass_in;          // 0 tight, 1 loose
   logic [SUM_BITS-1:0] sum_ff, sum_in, cand_ff, cand_in;
   logic [FREQ_BITS-1:0] f_ff, f_in;
   logic [3:0] raw_ff, raw_in;
   logic up_in;
   logic [HSUM_BITS-1:0] hsum_ff, hsum_in;
   logic [HIST_BITS-1:0] hidx_ff, hidx_in;
   logic out_v_ff, out_v_in;
   logic [3:0] sm_ff, sm_in;
   logic [15:0] sm_prod;
   div_req_type dreq; div_rsp_type drsp;
   logic edge_go, take_req;
   logic [TICK_BITS-1:0] p0, pn, pq, diff;
   logic [SLOT_BITS-1:0] pidx, qidx;
   logic [7:0] tol;
   logic [DIV_BITS-1:0] d4, st, fdiff;
   logic [2:0] s_pick;
   logic s_ok;

   spt_divider u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   assign req_ready = (state_ff == ST_IDLE) && !out_v_ff;
   assign take_req  = req_valid && req_ready;
   assign edge_go   = take_req && req_signal_high && !was_high_ff;
   assign csr_ready = 1'b1;

   // ring taps for the current candidate
   always_comb begin
      p0 = ring_ff[slot_ff];
      pidx = (slot_ff >= SLOT_BITS'(n_ff)) ? slot_ff - SLOT_BITS'(n_ff)
           : SLOT_BITS'(slot_ff + SLOT_BITS'(PERIOD_SLOTS) - SLOT_BITS'(n_ff));
      pn = ring_ff[pidx];
      // period n-1, the one added to the candidate sum
      qidx = (slot_ff >= SLOT_BITS'(n_ff - 3'd1)) ? slot_ff - SLOT_BITS'(n_ff - 3'd1)
           : SLOT_BITS'(slot_ff + SLOT_BITS'(PERIOD_SLOTS) - SLOT_BITS'(n_ff - 3'd1));
      pq = ring_ff[qidx];
      diff = (p0 > pn) ? p0 - pn : pn - p0;
      tol = pass_ff ? ltol_ff : ttol_ff;
   end

   // string select from frequency
   always_comb begin
      s_ok = 1'b1; s_pick = 3'd5;
      priority if ({8'd0, f_ff} < {14'd0, minf_ff, 8'd0}) s_ok = 1'b0;
      else if (f_ff < FREQ_BITS'(band_q8(3'd0))) s_pick = 3'd0;
      else if (f_ff < FREQ_BITS'(band_q8(3'd1))) s_pick = 3'd1;
      else if (f_ff < FREQ_BITS'(band_q8(3'd2))) s_pick = 3'd2;
      else if (f_ff < FREQ_BITS'(band_q8(3'd3))) s_pick = 3'd3;
      else if (f_ff < FREQ_BITS'(band_q8(3'd4))) s_pick = 3'd4;
      else if ({8'd0, f_ff} < {14'd0, maxf_ff, 8'd0}) s_pick = 3'd5;
      else s_ok = 1'b0;
      up_in = f_ff > FREQ_BITS'(tone_q8(s_pick));
      fdiff = up_in ? DIV_BITS'(f_ff) - DIV_BITS'(tone_q8(s_pick))
                    : DIV_BITS'(tone_q8(s_pick)) - DIV_BITS'(f_ff);
      d4 = fdiff << 10;
      st = up_in ? DIV_BITS'(up_q16(s_pick)) : DIV_BITS'(dn_q16(s_pick));
   end

   // sequencer
   always_comb begin
      state_in = state_ff; tick_in = tick_ff; was_high_in = was_high_ff;
      slot_in = slot_ff; hslot_in = hslot_ff; n_in = n_ff; pass_in = pass_ff;
      sum_in = sum_ff; cand_in = cand_ff; f_in = f_ff; raw_in = raw_ff;
      hsum_in = hsum_ff; hidx_in = hidx_ff; sm_in = sm_ff;
      sm_prod = '0;
      out_v_in = out_v_ff && !rsp_ready;
      dreq = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (take_req) begin
               if (edge_go) begin
                  slot_in = (slot_ff == SLOT_BITS'(PERIOD_SLOTS - 1)) ? '0
                          : slot_ff + 1'b1;
                  tick_in = TICK_BITS'(1); was_high_in = 1'b1;
                  n_in = 3'd1; pass_in = 1'b0; cand_in = '0; sum_in = SUM_BITS'(1);
                  state_in = ST_SRCH;
               end else begin
                  was_high_in = req_signal_high;
                  if (tick_ff != TICK_MAX) tick_in = tick_ff + 1'b1;
               end
            end
         end
         ST_SRCH: begin
            if (p0 == '0) begin
               sum_in = SUM_BITS'(1); state_in = ST_FREQ;
            end else begin
               cand_in = cand_ff + SUM_BITS'(pq);
               dreq.start = 1'b1;
               dreq.num = DIV_BITS'(rate_ff);
               dreq.den = DIV_BITS'(cand_in);
               state_in = ST_SWAIT;
            end
         end
         ST_SWAIT: begin
            if (drsp.done) begin
               if (diff <= TICK_BITS'(tol) && drsp.quot > DIV_BITS'(minf_ff)
                   && drsp.quot < DIV_BITS'(maxf_ff)) begin
                  sum_in = cand_ff; state_in = ST_FREQ;
               end else if (n_ff != 3'd4) begin
                  n_in = n_ff + 1'b1; state_in = ST_SRCH;
               end else if (!pass_ff) begin
                  pass_in = 1'b1; n_in = 3'd1; cand_in = '0; state_in = ST_SRCH;
               end else begin
                  sum_in = SUM_BITS'(1); state_in = ST_FREQ;
               end
            end
         end
         ST_FREQ: begin
            dreq.start = 1'b1;
            dreq.num = DIV_BITS'(rate_ff) * DIV_BITS'(GAIN_Q16)
                     + (DIV_BITS'(sum_ff) << 7);
            dreq.den = DIV_BITS'(sum_ff) << 8;
            state_in = ST_FWAIT;
         end
         ST_FWAIT: begin
            if (drsp.done) begin
               f_in = FREQ_BITS'(drsp.quot + DIV_BITS'(BUMP_Q8));
               state_in = ST_DET;
            end
         end
         ST_DET: begin
            if (!s_ok) begin
               raw_in = 4'd0; state_in = ST_HIST;
            end else if (up_in && d4 >= 7 * st) begin
               raw_in = 4'd9; state_in = ST_HIST;
            end else if (!up_in && d4 >= 9 * st) begin
               raw_in = 4'd1; state_in = ST_HIST;
            end else begin
               dreq.start = 1'b1;
               dreq.num = up_in ? 11 * st + d4 : 11 * st - d4;
               dreq.den = st << 1;
               state_in = ST_DWAIT;
            end
            hidx_in = '0; hsum_in = '0;
         end
         ST_DWAIT: begin
            if (drsp.done) begin
               raw_in = 4'(drsp.quot); state_in = ST_HIST;
            end
         end
         default: begin // ST_HIST: entry hslot holds raw, add one entry a cycle
            hsum_in = hsum_ff + HSUM_BITS'((hidx_ff == hslot_ff) ? raw_ff
                                          : hist_ff[hidx_ff]);
            if (hidx_ff == HIST_BITS'(HISTORY_DEPTH - 1)) begin
               // rounded mean by reciprocal multiply
               sm_prod = 16'(hsum_in + HSUM_BITS'(HISTORY_DEPTH / 2))
                       * 16'(SMOOTH_RECIP);
               sm_in = 4'(sm_prod >> SMOOTH_SHIFT);
               hslot_in = (hslot_ff == HIST_BITS'(HISTORY_DEPTH - 1)) ? '0
                        : hslot_ff + 1'b1;
               out_v_in = 1'b1; state_in = ST_IDLE;
            end else hidx_in = hidx_ff + 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      n_ff <= n_in; pass_ff <= pass_in; sum_ff <= sum_in; cand_ff <= cand_in;
      f_ff <= f_in; raw_ff <= raw_in;
      hsum_ff <= hsum_in; hidx_ff <= hidx_in; sm_ff <= sm_in;
      if (reset) begin
         state_ff <= ST_IDLE; tick_ff <= '0; was_high_ff <= 1'b0; slot_ff <= '0;
         hslot_ff <= '0; out_v_ff <= 1'b0;
         rate_ff <= 18'd70000; minf_ff <= 12'd70; maxf_ff <= 12'd350;
         ttol_ff <= 8'd5; ltol_ff <= 8'd15;
         for (int i = 0; i < PERIOD_SLOTS; i++) ring_ff[i] <= '0;
         for (int i = 0; i < HISTORY_DEPTH; i++) hist_ff[i] <= '0;
      end else begin
         state_ff <= state_in; tick_ff <= tick_in; was_high_ff <= was_high_in;
         slot_ff <= slot_in; hslot_ff <= hslot_in; out_v_ff <= out_v_in;
         if (edge_go) ring_ff[slot_in] <= tick_ff;
         if (state_ff == ST_HIST && state_in == ST_IDLE) hist_ff[hslot_ff] <= raw_ff;
         if (csr_valid) begin
            unique case (csr_index)
               CSR_SAMPLE_RATE: rate_ff <= csr_data[17:0];
               CSR_MIN_FREQ:    minf_ff <= csr_data[11:0];
               CSR_MAX_FREQ:    maxf_ff <= csr_data[11:0];
               CSR_TIGHT_TOL:   ttol_ff <= csr_data[7:0];
               CSR_LOOSE_TOL:   ltol_ff <= csr_data[7:0];
               default: ;
            endcase
         end
      end
   end

   assign rsp_valid          = out_v_ff;
   assign rsp_smoothed_index = sm_ff;
   assign rsp_led_pattern    = (sm_ff >= 4'd1 && sm_ff <= 4'd9) ? 9'(9'd1 << (sm_ff - 4'd1))
                                                                 : 9'd0;
   assign rsp_raw_index      = raw_ff;
   assign rsp_pattern_ticks  = sum_ff;
   assign rsp_freq_q8        = f_ff;

   `SPT_ASSERT_IMP(a_busy_not_ready, clock, reset, state_ff != ST_IDLE, !req_ready)
   `SPT_ASSERT_IMP(a_raw_range, clock, reset, rsp_valid, rsp_raw_index <= 4'd9)
   `SPT_ASSERT_NEXT(a_edge_starts, clock, reset, edge_go, state_ff == ST_SRCH)
   `SPT_ASSERT_IMP(a_led_onehot, clock, reset, rsp_valid, $onehot0(rsp_led_pattern))
endmodule

// File: rtl/spt_divider.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on spt_pkg.
module spt_divider import spt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);
   localparam int CNT_BITS = $clog2(DIV_BITS + 1);
   logic [DIV_BITS-1:0] quot_ff, quot_in, rem_ff, rem_in, den_ff, den_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic [DIV_BITS:0] trial;

   // shift one numerator bit into the remainder and try a subtract
   always_comb begin
      quot_in = quot_ff; rem_in = rem_ff; den_in = den_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0;
      trial = {rem_ff, quot_ff[DIV_BITS-1]} - {1'b0, den_ff};
      if (req.start) begin
         quot_in = req.num; rem_in = '0; den_in = req.den;
         cnt_in = CNT_BITS'(DIV_BITS); busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[DIV_BITS]) begin
            rem_in = trial[DIV_BITS-1:0];
            quot_in = {quot_ff[DIV_BITS-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[DIV_BITS-2:0], quot_ff[DIV_BITS-1]};
            quot_in = {quot_ff[DIV_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in; rem_ff <= rem_in; den_ff <= den_in; cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
   end

   assign rsp.done = done_ff;
   assign rsp.quot = quot_ff;
endmodule

// File: tb/string_pitch_tuner_test.sv
// Self-checking testbench for string_pitch_tuner: directed table, register
// extremes, then random comparator waveforms, checked against an in-bench
// pitch predictor. Depends on spt_pkg and the string_pitch_tuner RTL.
module string_pitch_tuner_test
   import spt_pkg::*;
   ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [3:0] CSR_UNMAPPED = 4'd9;
   localparam int         ITEM_TARGET  = 400;

   typedef struct {
      logic [8:0]           leds;
      logic [3:0]           smooth;
      logic [3:0]           raw;
      logic [SUM_BITS-1:0]  ticks;
      logic [FREQ_BITS-1:0] freq;
   } tuner_result_type;

   // directed row: level held for a count of samples, optional typed result
   typedef struct {
      bit               level;
      int               count;
      bit               typed;
      tuner_result_type want;
   } stim_row_type;

   logic                 clock, reset;
   logic                 req_valid, req_ready, req_signal_high;
   logic                 rsp_valid, rsp_ready;
   logic [8:0]           rsp_led_pattern;
   logic [3:0]           rsp_smoothed_index, rsp_raw_index;
   logic [SUM_BITS-1:0]  rsp_pattern_ticks;
   logic [FREQ_BITS-1:0] rsp_freq_q8;
   logic                 csr_valid, csr_ready;
   logic [3:0]           csr_index;
   logic [31:0]          csr_data;

   string_pitch_tuner dut (.*);

   // predictor state and register copies
   longint unsigned rate_hz, lo_hz, hi_hz, tol_tight, tol_loose;
   logic [TICK_BITS-1:0] tick_cnt;
   bit                   level_d;
   logic [TICK_BITS-1:0] periods [PERIOD_SLOTS];
   int                   slot_w;
   logic [3:0]           index_hist [HISTORY_DEPTH];
   int                   hist_w;

   localparam longint unsigned NOTE_Q8 [6] = '{21094, 28160, 37581, 50176, 63206, 84378};
   localparam longint unsigned STEP_UP [6] = '{321111, 428667, 572076, 763807, 962163,
                                               1284442};
   localparam longint unsigned STEP_DN [6] = '{303088, 404608, 539968, 720938, 908161,
                                               1212352};
   localparam longint unsigned EDGE_Q8 [5] = '{24627, 32870, 43878, 56678, 73805};

   tuner_result_type pending_results [$];
   bit               typed_next;
   tuner_result_type typed_want;
   bit               send_quiet, recv_quiet;
   int               recv_hold, errors, n_items, n_edges, n_checked, n_phases;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // repetition search over the five newest periods
   function automatic longint unsigned find_repeat(longint unsigned p [5],
                                                   longint unsigned tol);
      longint unsigned sum, diff, rate;
      sum = 0;
      if (p[0] == 0) return 1;
      for (int n = 1; n <= 4; n++) begin
         diff = (p[0] > p[n]) ? p[0] - p[n] : p[n] - p[0];
         sum += p[n-1];
         rate = rate_hz / sum;
         if (diff <= tol && rate > lo_hz && rate < hi_hz) return sum;
      end
      return 1;
   endfunction

   function automatic logic [3:0] detune_index(longint unsigned f, int s);
      longint unsigned t, d4, st;
      t = NOTE_Q8[s];
      if (f > t) begin
         d4 = (f - t) * 1024;
         st = STEP_UP[s];
         if (d4 >= 7 * st) return 4'd9;
         return 4'((11 * st + d4) / (2 * st));
      end
      d4 = (t - f) * 1024;
      st = STEP_DN[s];
      if (d4 >= 9 * st) return 4'd1;
      return 4'((11 * st - d4) / (2 * st));
   endfunction

   // advance the predictor by one accepted sample
   task automatic predict_sample(bit lvl);
      longint unsigned p [5];
      longint unsigned sum, f, hsum, smooth;
      tuner_result_type r;
      logic [3:0] raw;
      if (!lvl || level_d) begin
         level_d = lvl;
         if (tick_cnt != TICK_MAX) tick_cnt++;
         return;
      end
      slot_w = (slot_w + 1) % PERIOD_SLOTS;
      periods[slot_w] = tick_cnt;
      tick_cnt = TICK_BITS'(1);
      level_d = 1'b1;
      for (int k = 0; k < 5; k++)
         p[k] = periods[(slot_w + PERIOD_SLOTS - k) % PERIOD_SLOTS];
      sum = find_repeat(p, tol_tight);
      if (sum == 1) sum = find_repeat(p, tol_loose);
      f = (rate_hz * 64225 + 128 * sum) / (256 * sum) + 151;
      raw = 4'd0;
      if (f < lo_hz * 256) raw = 4'd0;
      else if (f < EDGE_Q8[0]) raw = detune_index(f, 0);
      else if (f < EDGE_Q8[1]) raw = detune_index(f, 1);
      else if (f < EDGE_Q8[2]) raw = detune_index(f, 2);
      else if (f < EDGE_Q8[3]) raw = detune_index(f, 3);
      else if (f < EDGE_Q8[4]) raw = detune_index(f, 4);
      else if (f < hi_hz * 256) raw = detune_index(f, 5);
      index_hist[hist_w] = raw;
      hist_w = (hist_w + 1) % HISTORY_DEPTH;
      hsum = 0;
      foreach (index_hist[k]) hsum += index_hist[k];
      smooth = (2 * hsum + HISTORY_DEPTH) / (2 * HISTORY_DEPTH);
      r.leds   = (smooth >= 1 && smooth <= 9) ? 9'(1 << (smooth - 1)) : 9'd0;
      r.smooth = smooth[3:0];
      r.raw    = raw;
      r.ticks  = sum[SUM_BITS-1:0];
      r.freq   = f[FREQ_BITS-1:0];
      if (typed_next) r = typed_want;
      typed_next = 1'b0;
      pending_results.push_back(r);
      n_edges++;
   endtask

   // one sample transaction; valid held across back-to-back samples
   task automatic send_sample(bit lvl);
      int gap;
      gap = send_quiet ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_signal_high <= lvl;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_sample(lvl);
      n_items++;
   endtask

   task automatic csr_write(logic [3:0] idx, longint unsigned value, int width);
      logic [31:0] mask;
      mask = (32'd1 << width) - 1;
      req_valid <= 1'b0;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= 32'(($urandom() & ~mask) | (value & mask));
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_SAMPLE_RATE: rate_hz   = value & mask;
         CSR_MIN_FREQ:    lo_hz     = value & mask;
         CSR_MAX_FREQ:    hi_hz     = value & mask;
         CSR_TIGHT_TOL:   tol_tight = value & mask;
         CSR_LOOSE_TOL:   tol_loose = value & mask;
         default: ;
      endcase
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic load_config(longint unsigned sr, longint unsigned mn, longint unsigned mx,
                              longint unsigned tt, longint unsigned tl);
      wait_idle();
      csr_write(CSR_SAMPLE_RATE, sr, 18);
      csr_write(CSR_MIN_FREQ, mn, 12);
      csr_write(CSR_MAX_FREQ, mx, 12);
      csr_write(CSR_TIGHT_TOL, tt, 8);
      csr_write(CSR_LOOSE_TOL, tl, 8);
   endtask

   // receiver stalls and result check
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_hold = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               $display("%0t: unexpected result leds=%h ticks=%0d", $realtime,
                        rsp_led_pattern, rsp_pattern_ticks);
               errors++;
            end else begin
               tuner_result_type w;
               w = pending_results.pop_front();
               n_checked++;
               if (rsp_led_pattern !== w.leds) begin
                  $display("%0t: led_pattern exp %h got %h", $realtime, w.leds,
                           rsp_led_pattern);
                  errors++;
               end
               if (rsp_smoothed_index !== w.smooth) begin
                  $display("%0t: smoothed_index exp %0d got %0d", $realtime, w.smooth,
                           rsp_smoothed_index);
                  errors++;
               end
               if (rsp_raw_index !== w.raw) begin
                  $display("%0t: raw_index exp %0d got %0d", $realtime, w.raw,
                           rsp_raw_index);
                  errors++;
               end
               if (rsp_pattern_ticks !== w.ticks) begin
                  $display("%0t: pattern_ticks exp %0d got %0d", $realtime, w.ticks,
                           rsp_pattern_ticks);
                  errors++;
               end
               if (rsp_freq_q8 !== w.freq) begin
                  $display("%0t: freq_q8 exp %0d got %0d", $realtime, w.freq, rsp_freq_q8);
                  errors++;
               end
            end
            recv_hold = recv_quiet ? 0 : $urandom_range(0, 18);
         end else if (recv_hold > 0) begin
            recv_hold--;
         end
         rsp_ready <= (recv_hold == 0);
      end
   end

   initial begin
      #18ms;
      $display("string_pitch_tuner_test: errors");
      $finish;
   end

   // main sequence
   initial begin
      stim_row_type rows [$];
      stim_row_type row;
      int hi_len, lo_len, alt_len, shape, phase_items;

      reset = 1'b1;
      req_valid = 1'b0;
      req_signal_high = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_SAMPLE_RATE;
      csr_data = '0;
      rate_hz = 70000; lo_hz = 70; hi_hz = 350; tol_tight = 5; tol_loose = 15;
      tick_cnt = '0; level_d = 1'b0; slot_w = 0; hist_w = 0;
      foreach (periods[k]) periods[k] = '0;
      foreach (index_hist[k]) index_hist[k] = '0;
      typed_next = 1'b0; send_quiet = 1'b0; recv_quiet = 1'b0;
      errors = 0; n_items = 0; n_edges = 0; n_checked = 0; n_phases = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: zero newest period right after reset, a steady tone,
      // then very short periods
      row = '{1'b1, 1, 1'b1, '{9'd0, 4'd0, 4'd0, 18'd1, 26'd17561674}};
      rows.push_back(row);
      rows.push_back('{1'b0, 19, 1'b0, '{default: '0}});
      for (int k = 0; k < 5; k++) begin
         rows.push_back('{1'b1, 10, 1'b0, '{default: '0}});
         rows.push_back('{1'b0, 10, 1'b0, '{default: '0}});
      end
      rows.push_back('{1'b1, 3, 1'b0, '{default: '0}});
      rows.push_back('{1'b0, 7, 1'b0, '{default: '0}});
      for (int k = 0; k < 5; k++) begin
         rows.push_back('{1'b1, 1, 1'b0, '{default: '0}});
         rows.push_back('{1'b0, 1, 1'b0, '{default: '0}});
      end
      foreach (rows[i]) begin
         send_quiet = (rows[i].count > 1000);
         for (int k = 0; k < rows[i].count; k++) begin
            typed_next = rows[i].typed && (k == 0);
            typed_want = rows[i].want;
            send_sample(rows[i].level);
         end
      end
      send_quiet = 1'b0;

      // unmapped index must be ignored; then register extremes
      wait_idle();
      csr_write(CSR_UNMAPPED, $urandom(), 32);
      load_config(200000, 1, 4000, 0, 255);
      for (int k = 0; k < 6; k++) begin
         send_sample(1'b1);
         repeat (k % 2 ? 7 : 3) send_sample(1'b0);
      end
      load_config(1000, 4000, 1, 255, 0);
      repeat (4) begin
         send_sample(1'b1);
         repeat (4) send_sample(1'b0);
      end

      // random phases of periodic or noise waveforms with random registers
      while (n_items < ITEM_TARGET) begin
         n_phases++;
         load_config($urandom_range(1000, 6000), $urandom_range(1, 4) == 1 ?
                     $urandom_range(1, 4000) : $urandom_range(1, 150),
                     $urandom_range(1, 4) == 1 ? $urandom_range(1, 4000) :
                     $urandom_range(250, 4000),
                     $urandom_range(0, 3) == 0 ? $urandom_range(0, 255) : $urandom_range(0, 3),
                     $urandom_range(0, 3) == 0 ? $urandom_range(0, 255) : $urandom_range(0, 8));
         send_quiet = ($urandom_range(0, 3) == 0);
         recv_quiet = ($urandom_range(0, 3) == 0);
         shape  = $urandom_range(0, 4);
         hi_len = $urandom_range(1, 8);
         lo_len = $urandom_range(1, 10);
         alt_len = $urandom_range(1, 10);
         phase_items = 0;
         while (phase_items < 50) begin
            if (shape == 0) begin
               // noise
               send_sample($urandom_range(0, 1));
               phase_items++;
            end else begin
               repeat (hi_len) send_sample(1'b1);
               if (shape == 2) repeat (alt_len) send_sample(1'b0);
               else if (shape == 3) repeat (lo_len + $urandom_range(0, 2)) send_sample(1'b0);
               else repeat (lo_len) send_sample(1'b0);
               phase_items += hi_len + lo_len;
               if (shape == 2) begin
                  repeat (hi_len) send_sample(1'b1);
                  repeat (lo_len) send_sample(1'b0);
                  phase_items += hi_len + alt_len;
               end
            end
         end
      end
      req_valid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (600) @(posedge clock);
      $display("covered %0d samples, %0d rising edges, %0d results checked", n_items,
               n_edges, n_checked);
      $display("random waveform phases with fresh registers: %0d", n_phases);
      if (errors == 0 && pending_results.size() == 0)
         $display("string_pitch_tuner_test: clean");
      else
         $display("string_pitch_tuner_test: errors");
      $finish;
   end
endmodule

// File: string_pitch_tuner.f
+incdir+rtl
rtl/spt_pkg.sv
rtl/spt_divider.sv
rtl/string_pitch_tuner.sv
tb/string_pitch_tuner_test.sv
